FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cddb_pkg.sv
package cddb_pkg;

  // Field widths of the track and result transactions.
  localparam int unsigned MIN_W   = 7;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned FRM_W   = 7;
  localparam int unsigned OFS_W   = 19;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned DSEC_W  = 14;

  // Internal widths.
  localparam int unsigned FRAMES_W = 20;  // start or length in frames
  localparam int unsigned DVD_W    = 21;  // start + 1 + length in frames
  localparam int unsigned SECS_W   = 13;  // start in whole seconds
  localparam int unsigned REM_W    = 7;   // divider remainder, below 75
  localparam int unsigned BCD_DIGITS = 4;
  localparam int unsigned BCD_W    = 4 * BCD_DIGITS;
  localparam int unsigned DSUM_W   = 6;   // sum of four decimal digits
  localparam int unsigned SUM_W    = 8;   // running sum, held modulo 255
  localparam int unsigned SPAN_W   = 16;
  localparam int unsigned CNT_W    = $clog2(DVD_W);

  // Arithmetic constants.
  localparam int unsigned FRAMES_PER_SEC = 75;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned FRAMES_PER_MIN = FRAMES_PER_SEC * SECS_PER_MIN;
  localparam int unsigned SUM_MOD        = 255;
  localparam int unsigned OFFSET_MAX     = (1 << OFS_W) - 1;
  localparam int unsigned DIGIT_ADJ_MIN  = 5;
  localparam int unsigned DIGIT_ADJ      = 3;
  localparam int unsigned DIGIT_MAX      = 9;

  localparam int unsigned DEFAULT_MAX_TRACKS = 99;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_FINISH
  } seq_state_t;

  // Controls from the sequencer to the serial datapaths.
  typedef struct packed {
    logic load;
    logic div_step;
    logic bcd_step;
  } ser_ctrl_t;

endpackage

FILE: sv/cddb_ifs.sv
// Track channel: one table-of-contents entry per transaction.
interface cddb_in_if;
  logic                         valid;
  logic                         ready;
  logic [cddb_pkg::MIN_W-1:0]   start_minute;
  logic [cddb_pkg::SEC_W-1:0]   start_second;
  logic [cddb_pkg::FRM_W-1:0]   start_frame;
  logic [cddb_pkg::MIN_W-1:0]   length_minute;
  logic [cddb_pkg::SEC_W-1:0]   length_second;
  logic [cddb_pkg::FRM_W-1:0]   length_frame;
  logic                         last_track;

  modport source (
    output valid, start_minute, start_second, start_frame,
           length_minute, length_second, length_frame, last_track,
    input  ready
  );
  modport sink (
    input  valid, start_minute, start_second, start_frame,
           length_minute, length_second, length_frame, last_track,
    output ready
  );
endinterface

// Result channel: one result per track.
interface cddb_out_if;
  logic                         valid;
  logic                         ready;
  logic [cddb_pkg::OFS_W-1:0]   frame_offset;
  logic                         id_valid;
  logic [cddb_pkg::ID_W-1:0]    disc_id;
  logic [cddb_pkg::DSEC_W-1:0]  disc_seconds;

  modport source (
    output valid, frame_offset, id_valid, disc_id, disc_seconds,
    input  ready
  );
  modport sink (
    input  valid, frame_offset, id_valid, disc_id, disc_seconds,
    output ready
  );
endinterface

FILE: sv/cddb_bcd.sv
`include "assert_macros.svh"

// Bit-serial binary to BCD converter (shift and add 3), one input bit per step.
// Delivers the sum of the decimal digits once all bits have been shifted in.
module cddb_bcd (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cddb_pkg::ser_ctrl_t             ctrl,
  input  logic [cddb_pkg::SECS_W-1:0]     bin_in,
  output logic [cddb_pkg::DSUM_W-1:0]     digit_sum
);

  localparam int unsigned BCD_W  = cddb_pkg::BCD_W;
  localparam int unsigned SECS_W = cddb_pkg::SECS_W;
  localparam int unsigned DSUM_W = cddb_pkg::DSUM_W;

  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [SECS_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]  bcd_adj;
  logic              digits_ok;

  // Add three to every digit of five or more, then shift the next bit in.
  always_comb begin
    bcd_adj   = bcd_r;
    digit_sum = '0;
    digits_ok = 1'b1;
    for (int i = 0; i < cddb_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'(cddb_pkg::DIGIT_ADJ_MIN)) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'(cddb_pkg::DIGIT_ADJ);
      end
      digit_sum = digit_sum + DSUM_W'(bcd_r[4*i +: 4]);
      if (bcd_r[4*i +: 4] > 4'(cddb_pkg::DIGIT_MAX)) begin
        digits_ok = 1'b0;
      end
    end

    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    if (ctrl.load) begin
      bcd_nxt = '0;
      bin_nxt = bin_in;
    end else if (ctrl.bcd_step) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[SECS_W-1]};
      bin_nxt = {bin_r[SECS_W-2:0], 1'b0};
    end
  end

  // Shift registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcd_r <= '0;
      bin_r <= '0;
    end else begin
      bcd_r <= bcd_nxt;
      bin_r <= bin_nxt;
    end
  end

  // Every BCD digit stays a decimal digit throughout the conversion.
  `ASSERT_ALWAYS(a_bcd_digits, digits_ok, "BCD digit above nine")
  // A load always starts from a cleared digit register.
  `ASSERT_NEXT(a_bcd_load, ctrl.load, bcd_r == '0, "BCD register not cleared on load")

endmodule

FILE: sv/cddb_div75.sv
`include "assert_macros.svh"

// Restoring divider by 75, one dividend bit per step. The quotient bits
// replace the dividend bits in the same shift register.
module cddb_div75 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cddb_pkg::ser_ctrl_t           ctrl,
  input  logic [cddb_pkg::DVD_W-1:0]    dividend,
  output logic [cddb_pkg::DVD_W-1:0]    quotient
);

  localparam int unsigned DVD_W = cddb_pkg::DVD_W;
  localparam int unsigned REM_W = cddb_pkg::REM_W;

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   trial_sub;
  logic             fits;

  // Bring down the next bit and subtract the divisor where it fits.
  always_comb begin
    trial     = {rem_r, dvd_r[DVD_W-1]};
    trial_sub = trial - (REM_W+1)'(cddb_pkg::FRAMES_PER_SEC);
    fits      = trial >= (REM_W+1)'(cddb_pkg::FRAMES_PER_SEC);

    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    if (ctrl.load) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (ctrl.div_step) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], fits};
      rem_nxt = fits ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
    end
  end

  assign quotient = dvd_r;

  // Dividend/quotient and remainder registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvd_r <= '0;
      rem_r <= '0;
    end else begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  // The partial remainder always stays below the divisor.
  `ASSERT_ALWAYS(a_div_rem, rem_r < REM_W'(cddb_pkg::FRAMES_PER_SEC), "remainder not below 75")

endmodule

FILE: sv/cddb_disc_id_generator_top.sv
// CDDB disc id generator.
// in_ch carries one table-of-contents track per transaction: start and length
// as minute/second/frame and a last_track flag. out_ch returns one result per
// track: the absolute start frame, and on the last track the disc id and the
// disc length in seconds (zero otherwise). The running digit sum, track count
// and first start are cleared after the last track of each disc.
// Steps: an accepted track's fields are captured; the load state converts them
// to frames and seconds and loads the serial datapaths; the run state does the
// bit-serial divide by 75, the BCD digit sum running alongside until all bits
// of the start seconds are in; the finish state updates the totals and loads
// the output register. A new track is taken only once the last is through:
// in_ch.ready is high only while the sequencer is idle. The output register
// parts the two sides, so the next track is taken while a result still waits.
// When out_ch.ready stays low, the result holds and the sequencer waits in its
// finish state until the output register frees.
// Reset (rst_n low at a clock edge) empties the block and clears the totals.
`include "assert_macros.svh"

module cddb_disc_id_generator_top #(
  parameter int unsigned MAX_TRACKS = cddb_pkg::DEFAULT_MAX_TRACKS
) (
  input  logic       clk,
  input  logic       rst_n,
  cddb_in_if.sink    in_ch,
  cddb_out_if.source out_ch
);

  localparam int unsigned TC_W     = $clog2(MAX_TRACKS + 1);
  localparam int unsigned FRAMES_W = cddb_pkg::FRAMES_W;
  localparam int unsigned DVD_W    = cddb_pkg::DVD_W;
  localparam int unsigned SECS_W   = cddb_pkg::SECS_W;
  localparam int unsigned SUM_W    = cddb_pkg::SUM_W;
  localparam int unsigned SPAN_W   = cddb_pkg::SPAN_W;
  localparam int unsigned DSEC_W   = cddb_pkg::DSEC_W;
  localparam int unsigned OFS_W    = cddb_pkg::OFS_W;
  localparam int unsigned CNT_W    = cddb_pkg::CNT_W;

  cddb_pkg::seq_state_t state_r, state_nxt;
  cddb_pkg::ser_ctrl_t  ctrl;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Captured track fields.
  logic [cddb_pkg::MIN_W-1:0] sm_r, lm_r;
  logic [cddb_pkg::SEC_W-1:0] ss_r, ls_r;
  logic [cddb_pkg::FRM_W-1:0] sf_r, lf_r;
  logic                       last_r;

  // Values formed in the load cycle.
  logic [FRAMES_W-1:0] start_frames, len_frames;
  logic [DVD_W-1:0]    dividend;
  logic [SECS_W-1:0]   start_secs;
  logic [SECS_W-1:0]   start_secs_r;
  logic [OFS_W-1:0]    offset_r;

  // Per-disc totals.
  logic [TC_W-1:0]   tc_r, tc_new;
  logic [SUM_W-1:0]  sum_r, sum_new;
  logic [SECS_W-1:0] first_r, first_new;
  logic [SUM_W:0]    sum_wide;

  logic [cddb_pkg::DSUM_W-1:0] digit_sum;
  logic [DVD_W-1:0]            quotient;
  logic [DSEC_W-1:0]           disc_secs;
  logic [SPAN_W-1:0]           span;

  logic accept;
  logic finish_fire;

  // Output register.
  logic                      out_valid_r;
  logic [OFS_W-1:0]          out_offset_r;
  logic                      out_id_valid_r;
  logic [cddb_pkg::ID_W-1:0] out_disc_id_r;
  logic [DSEC_W-1:0]         out_disc_secs_r;

  assign in_ch.ready = (state_r == cddb_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign finish_fire = (state_r == cddb_pkg::ST_FINISH) && (!out_valid_r || out_ch.ready);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cddb_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Sequencer next state and datapath controls.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ctrl.load     = 1'b0;
    ctrl.div_step = 1'b0;
    ctrl.bcd_step = 1'b0;
    unique case (state_r)
      cddb_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = cddb_pkg::ST_LOAD;
        end
      end
      cddb_pkg::ST_LOAD: begin
        ctrl.load = 1'b1;
        cnt_nxt   = '0;
        state_nxt = cddb_pkg::ST_RUN;
      end
      cddb_pkg::ST_RUN: begin
        ctrl.div_step = 1'b1;
        ctrl.bcd_step = (cnt_r < CNT_W'(SECS_W));
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          state_nxt = cddb_pkg::ST_FINISH;
        end
      end
      cddb_pkg::ST_FINISH: begin
        if (finish_fire) begin
          state_nxt = cddb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cddb_pkg::ST_IDLE;
    endcase
  end

  // Capture the track fields on each accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      sm_r   <= in_ch.start_minute;
      ss_r   <= in_ch.start_second;
      sf_r   <= in_ch.start_frame;
      lm_r   <= in_ch.length_minute;
      ls_r   <= in_ch.length_second;
      lf_r   <= in_ch.length_frame;
      last_r <= in_ch.last_track;
    end
  end

  // Convert minute/second/frame to frames and seconds.
  always_comb begin
    start_frames = FRAMES_W'(sm_r) * FRAMES_W'(cddb_pkg::FRAMES_PER_MIN)
                 + FRAMES_W'(ss_r) * FRAMES_W'(cddb_pkg::FRAMES_PER_SEC)
                 + FRAMES_W'(sf_r);
    len_frames   = FRAMES_W'(lm_r) * FRAMES_W'(cddb_pkg::FRAMES_PER_MIN)
                 + FRAMES_W'(ls_r) * FRAMES_W'(cddb_pkg::FRAMES_PER_SEC)
                 + FRAMES_W'(lf_r);
    dividend     = DVD_W'(start_frames) + DVD_W'(len_frames) + DVD_W'(1);
    start_secs   = SECS_W'(sm_r) * SECS_W'(cddb_pkg::SECS_PER_MIN) + SECS_W'(ss_r);
  end

  // Hold the saturated offset and start seconds for the final cycle.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      start_secs_r <= start_secs;
      offset_r     <= (start_frames > FRAMES_W'(cddb_pkg::OFFSET_MAX))
                      ? OFS_W'(cddb_pkg::OFFSET_MAX) : start_frames[OFS_W-1:0];
    end
  end

  cddb_bcd u_bcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .bin_in    (start_secs),
    .digit_sum (digit_sum)
  );

  cddb_div75 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .dividend (dividend),
    .quotient (quotient)
  );

  // Updated totals and the disc id fields.
  always_comb begin
    tc_new    = (tc_r < TC_W'(MAX_TRACKS)) ? tc_r + 1'b1 : tc_r;
    first_new = (tc_r == '0) ? start_secs_r : first_r;
    sum_wide  = (SUM_W+1)'(sum_r) + (SUM_W+1)'(digit_sum);
    sum_new   = (sum_wide >= (SUM_W+1)'(cddb_pkg::SUM_MOD))
                ? SUM_W'(sum_wide - (SUM_W+1)'(cddb_pkg::SUM_MOD)) : SUM_W'(sum_wide);
    disc_secs = quotient[DSEC_W-1:0];
    span      = SPAN_W'(disc_secs) - SPAN_W'(first_new);
  end

  // Per-disc totals; cleared after the last track.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r    <= '0;
      sum_r   <= '0;
      first_r <= '0;
    end else if (finish_fire) begin
      if (last_r) begin
        tc_r    <= '0;
        sum_r   <= '0;
        first_r <= '0;
      end else begin
        tc_r    <= tc_new;
        sum_r   <= sum_new;
        first_r <= first_new;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (finish_fire) begin
      out_offset_r    <= offset_r;
      out_id_valid_r  <= last_r;
      out_disc_id_r   <= last_r ? {sum_new, span, 8'(tc_new)} : '0;
      out_disc_secs_r <= last_r ? disc_secs : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_offset = out_offset_r;
  assign out_ch.id_valid     = out_id_valid_r;
  assign out_ch.disc_id      = out_disc_id_r;
  assign out_ch.disc_seconds = out_disc_secs_r;

  // The track count saturates and the running sum stays reduced.
  `ASSERT_ALWAYS(a_tc_sat, tc_r <= TC_W'(MAX_TRACKS), "track count above its limit")
  `ASSERT_ALWAYS(a_sum_mod, sum_r < SUM_W'(cddb_pkg::SUM_MOD), "running sum not reduced")
  // A waiting result is never dropped.
  `ASSERT_NEXT(a_out_hold, out_valid_r && !out_ch.ready, out_valid_r, "pending result lost")
  // The totals start over after the last track of a disc.
  `ASSERT_NEXT(a_disc_clear, finish_fire && last_r, tc_r == '0 && sum_r == '0, "totals not cleared")

endmodule
